>>> rtl/vpa_pkg.sv
// Package: shared types and constants for the variable partition allocator.
package vpa_pkg;

   localparam int unsigned AddrWidth   = 15;
   localparam int unsigned PoolSize    = 32767;
   localparam int unsigned MaxSegments = 32;
   localparam int unsigned IdxWidth    = $clog2(MaxSegments);
   localparam int unsigned CntWidth    = $clog2(MaxSegments + 1);

   localparam logic       OP_ALLOC   = 1'b0;
   localparam logic       OP_RELEASE = 1'b1;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic                 operation;
      logic [AddrWidth-1:0] segment_size;
      logic [AddrWidth-1:0] segment_address;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [AddrWidth-1:0] granted_address;
   } rsp_type;

   // one free segment as stored in the table memory
   typedef struct packed {
      logic [AddrWidth-1:0] base;
      logic [AddrWidth-1:0] length;
   } seg_type;

endpackage

>>> rtl/vpa_seg_ram.sv
// Segment table memory: one write port, one registered read port.
module vpa_seg_ram
   import vpa_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IdxWidth-1:0] wr_addr,
   input  seg_type             wr_data,
   input  logic [IdxWidth-1:0] rd_addr,
   output seg_type             rd_data
);

   seg_type mem [MaxSegments];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/variable_partition_allocator_core.sv
// Variable partition allocator: free-segment table with first/best fit and coalescing.
//
// Channels: req_ carries one request beat (allocate or release), rsp_ returns one
// result beat per request, csr_ writes the one-bit fit policy (0 first, 1 best).
// Free segments are kept sorted by base in a single-port-write, registered-read
// table memory; the sequencer below walks it one entry a cycle.
// Per request: a scan over the N live entries, followed by a shift pass over the
// entries above the removal or insertion point when an entry is removed or
// inserted, then a handoff through the decide and done states. The table memory
// read port sets the pace of both passes.
// Reset: count goes to one; entry 0 is written with base 0, length of the whole
// pool in the init state after reset, and requests are taken from the idle state
// that follows. Only one request is in flight at a time; the result sits in an
// output register until rsp_ready, and the next request is accepted only once
// that register is free.
module variable_partition_allocator_core
   import vpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_DEC   = 7'b0001000,
      S_DROP  = 7'b0010000,
      S_INS   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic policy_ff;
   logic [CntWidth-1:0] count_ff, count_in;
   req_type req_ff;
   // scan pointer: index whose read data arrives next cycle
   logic [CntWidth-1:0] idx_ff, idx_in;
   logic                rvalid_ff, rvalid_in;
   logic [CntWidth-1:0] ridx_ff, ridx_in;
   // scan findings
   logic                found_ff, found_in;
   logic                exact_ff, exact_in;
   logic [IdxWidth-1:0] pick_ff, pick_in;
   logic [AddrWidth-1:0] best_ff, best_in;
   seg_type             pseg_ff, pseg_in;
   logic                ovl_ff, ovl_in;
   logic [CntWidth-1:0] pos_ff, pos_in;
   seg_type             prev_ff, prev_in;   // entry pos-1
   seg_type             next_ff, next_in;   // entry pos
   logic                gotpos_ff, gotpos_in;
   logic [CntWidth-1:0] mv_ff, mv_in;       // shift pointer
   seg_type             fix_ff, fix_in;     // entry written at the end of the insert shift
   logic [CntWidth-1:0] fixi_ff, fixi_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                we;
   logic [IdxWidth-1:0] wa, ra;
   seg_type             wd, rd;

   vpa_seg_ram u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa),
      .wr_data(wd),
      .rd_addr(ra),
      .rd_data(rd)
   );

   logic [AddrWidth:0] rel_end, seg_end;
   assign rel_end = {1'b0, req_ff.segment_address} + {1'b0, req_ff.segment_size};
   assign seg_end = {1'b0, rd.base} + {1'b0, rd.length};

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [AddrWidth-1:0] left;
      logic jp, jn;
      state_in = state_ff;  count_in = count_ff;
      idx_in = idx_ff;  rvalid_in = 1'b0;  ridx_in = idx_ff;
      found_in = found_ff;  exact_in = exact_ff;  pick_in = pick_ff;
      best_in = best_ff;  pseg_in = pseg_ff;  ovl_in = ovl_ff;
      pos_in = pos_ff;  prev_in = prev_ff;  next_in = next_ff;
      gotpos_in = gotpos_ff;  mv_in = mv_ff;  fix_in = fix_ff;  fixi_in = fixi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;  rsp_in = rsp_ff;
      we = 1'b0;  wa = '0;  wd = '0;  ra = idx_ff[IdxWidth-1:0];
      left = rd.length - req_ff.segment_size;
      jp = 1'b0;  jn = 1'b0;
      case (state_ff)
         S_INIT: begin
            we = 1'b1;  wa = '0;
            wd.base = '0;  wd.length = AddrWidth'(PoolSize);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            idx_in = '0;  found_in = 1'b0;  exact_in = 1'b0;  ovl_in = 1'b0;
            gotpos_in = 1'b0;  pos_in = count_ff;  pick_in = '0;  best_in = '0;
            if (req_valid && req_ready) state_in = S_SCAN;
         end
         S_SCAN: begin
            // issue read of idx, evaluate data of previous read
            ra = idx_ff[IdxWidth-1:0];
            if (idx_ff < count_ff) begin
               rvalid_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (rvalid_ff && !exact_ff) begin
               if (req_ff.operation == OP_ALLOC) begin
                  if (rd.length == req_ff.segment_size) begin
                     if (!(found_ff && !policy_ff)) begin
                        exact_in = 1'b1;  found_in = 1'b1;
                        pick_in = ridx_ff[IdxWidth-1:0];  pseg_in = rd;
                     end
                  end else if (rd.length > req_ff.segment_size) begin
                     if (!found_ff || (policy_ff && left < best_ff)) begin
                        found_in = 1'b1;  best_in = left;
                        pick_in = ridx_ff[IdxWidth-1:0];  pseg_in = rd;
                     end
                  end
               end else begin
                  if ({1'b0, req_ff.segment_address} < seg_end &&
                      {1'b0, rd.base} < rel_end) ovl_in = 1'b1;
                  if (!gotpos_ff) begin
                     if (rd.base < req_ff.segment_address) prev_in = rd;
                     else begin
                        gotpos_in = 1'b1;  pos_in = ridx_ff;  next_in = rd;
                     end
                  end
               end
            end
            if (!(idx_ff < count_ff) && !rvalid_ff) state_in = S_DEC;
         end
         S_DEC: begin
            rsp_in.granted_address = '0;
            rsp_in.status = ST_OK;
            state_in = S_DONE;
            if (req_ff.segment_size == '0) rsp_in.status = ST_INVALID;
            else if (req_ff.operation == OP_ALLOC) begin
               if (!found_ff) rsp_in.status = ST_NOFIT;
               else begin
                  rsp_in.granted_address = pseg_ff.base;
                  if (pseg_ff.length == req_ff.segment_size) begin
                     mv_in = {1'b0, pick_ff};
                     state_in = S_DROP;
                  end else begin
                     we = 1'b1;  wa = pick_ff;
                     wd.base = pseg_ff.base + req_ff.segment_size;
                     wd.length = pseg_ff.length - req_ff.segment_size;
                  end
               end
            end else begin
               jp = (pos_ff != '0) &&
                    ({1'b0, prev_ff.base} + {1'b0, prev_ff.length} ==
                     {1'b0, req_ff.segment_address});
               jn = (pos_ff < count_ff) && ({1'b0, next_ff.base} == rel_end);
               if (rel_end > (AddrWidth+1)'(PoolSize) || ovl_ff)
                  rsp_in.status = ST_INVALID;
               else if (jp && jn) begin
                  we = 1'b1;  wa = IdxWidth'(pos_ff - 1'b1);
                  wd.base = prev_ff.base;
                  wd.length = prev_ff.length + req_ff.segment_size + next_ff.length;
                  mv_in = pos_ff;
                  state_in = S_DROP;
               end else if (jp) begin
                  we = 1'b1;  wa = IdxWidth'(pos_ff - 1'b1);
                  wd.base = prev_ff.base;
                  wd.length = prev_ff.length + req_ff.segment_size;
               end else if (jn) begin
                  we = 1'b1;  wa = IdxWidth'(pos_ff);
                  wd.base = req_ff.segment_address;
                  wd.length = next_ff.length + req_ff.segment_size;
               end else if (count_ff >= CntWidth'(MaxSegments))
                  rsp_in.status = ST_FULL;
               else begin
                  fix_in.base = req_ff.segment_address;
                  fix_in.length = req_ff.segment_size;
                  fixi_in = pos_ff;
                  mv_in = count_ff;
                  state_in = S_INS;
               end
            end
         end
         S_DROP: begin
            // entry mv <- entry mv+1; read of mv+1 issued the cycle before
            ra = IdxWidth'(mv_ff + 1'b1);
            rvalid_in = 1'b1;
            if (rvalid_ff) begin
               we = 1'b1;  wa = IdxWidth'(mv_ff);  wd = rd;
               mv_in = mv_ff + 1'b1;
               ra = IdxWidth'(mv_ff + 2'd2);
            end
            if (mv_ff + 1'b1 >= count_ff) begin
               we = 1'b0;  rvalid_in = 1'b0;
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_INS: begin
            // entry mv <- entry mv-1, walking down to pos
            ra = IdxWidth'(mv_ff - 1'b1);
            rvalid_in = 1'b1;
            if (mv_ff == fixi_ff) begin
               we = 1'b1;  wa = IdxWidth'(fixi_ff);  wd = fix_ff;
               rvalid_in = 1'b0;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else if (rvalid_ff) begin
               we = 1'b1;  wa = IdxWidth'(mv_ff);  wd = rd;
               mv_in = mv_ff - 1'b1;
               ra = IdxWidth'(mv_ff - 2'd2);
               rvalid_in = (mv_ff - 1'b1) != fixi_ff;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         policy_ff <= 1'b0;
         count_ff <= CntWidth'(1);
         rvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) policy_ff <= csr_data;
         count_ff <= count_in;
         rvalid_ff <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      idx_ff <= idx_in;  ridx_ff <= ridx_in;
      found_ff <= found_in;  exact_ff <= exact_in;  pick_ff <= pick_in;
      best_ff <= best_in;  pseg_ff <= pseg_in;  ovl_ff <= ovl_in;
      pos_ff <= pos_in;  prev_ff <= prev_in;  next_ff <= next_in;
      gotpos_ff <= gotpos_in;  mv_ff <= mv_in;  fix_ff <= fix_in;  fixi_ff <= fixi_in;
      rsp_ff <= rsp_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(MaxSegments))
      else $error("segment count out of range");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff)
      else $error("result lost after finish");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff && state_ff == S_IDLE)
      else $error("accept while busy");

endmodule

>>> dv/vpa_checker.sv
// Checker: predicts allocator results from observed beats and compares them.
`timescale 1ns / 1ps
module vpa_checker
   import vpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_data,
   output int      fail_count,
   output int      pending_count
);

   logic                 policy;
   logic [AddrWidth-1:0] seg_base [MaxSegments];
   logic [AddrWidth-1:0] seg_len  [MaxSegments];
   int                   seg_cnt;
   rsp_type              expected_rsp_q[$];

   function automatic void remove_seg(int k);
      for (int i = k; i + 1 < seg_cnt; i++) begin
         seg_base[i] = seg_base[i+1];
         seg_len[i]  = seg_len[i+1];
      end
      seg_cnt--;
   endfunction

   function automatic rsp_type predict_alloc_release(req_type r);
      rsp_type o;
      int      size, addr, stop, pick, best, pos, left, b, e;
      bit      found, jp, jn;
      o = '0;
      size = int'(r.segment_size);
      addr = int'(r.segment_address);
      if (r.operation == OP_ALLOC) begin
         found = 0;
         pick = 0;
         best = 0;
         if (size == 0) begin
            o.status = ST_INVALID;
            return o;
         end
         for (int i = 0; i < seg_cnt; i++) begin
            if (policy == 1'b0) begin
               if (seg_len[i] >= size) begin
                  pick = i;
                  found = 1;
                  break;
               end
            end else begin
               if (seg_len[i] == size) begin
                  pick = i;
                  found = 1;
                  break;
               end
               if (seg_len[i] > size) begin
                  left = int'(seg_len[i]) - size;
                  if (!found || left < best) begin
                     best = left;
                     pick = i;
                     found = 1;
                  end
               end
            end
         end
         if (!found) begin
            o.status = ST_NOFIT;
            return o;
         end
         o.status = ST_OK;
         o.granted_address = seg_base[pick];
         if (seg_len[pick] == size) remove_seg(pick);
         else begin
            seg_base[pick] = AddrWidth'(int'(seg_base[pick]) + size);
            seg_len[pick]  = AddrWidth'(int'(seg_len[pick]) - size);
         end
         return o;
      end
      stop = addr + size;
      if (size == 0 || stop > PoolSize) begin
         o.status = ST_INVALID;
         return o;
      end
      for (int i = 0; i < seg_cnt; i++) begin
         b = int'(seg_base[i]);
         e = b + int'(seg_len[i]);
         if (addr < e && b < stop) begin
            o.status = ST_INVALID;
            return o;
         end
      end
      pos = 0;
      while (pos < seg_cnt && seg_base[pos] < addr) pos++;
      jp = pos > 0 && (int'(seg_base[pos-1]) + int'(seg_len[pos-1]) == addr);
      jn = pos < seg_cnt && seg_base[pos] == stop;
      if (jp && jn) begin
         seg_len[pos-1] = AddrWidth'(int'(seg_len[pos-1]) + size + int'(seg_len[pos]));
         remove_seg(pos);
      end else if (jp) begin
         seg_len[pos-1] = AddrWidth'(int'(seg_len[pos-1]) + size);
      end else if (jn) begin
         seg_base[pos] = AddrWidth'(addr);
         seg_len[pos]  = AddrWidth'(int'(seg_len[pos]) + size);
      end else begin
         if (seg_cnt >= MaxSegments) begin
            o.status = ST_FULL;
            return o;
         end
         for (int i = seg_cnt; i > pos; i--) begin
            seg_base[i] = seg_base[i-1];
            seg_len[i]  = seg_len[i-1];
         end
         seg_base[pos] = AddrWidth'(addr);
         seg_len[pos]  = AddrWidth'(size);
         seg_cnt++;
      end
      o.status = ST_OK;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         policy = 1'b0;
         seg_cnt = 1;
         seg_base[0] = '0;
         seg_len[0] = AddrWidth'(PoolSize);
         fail_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) policy = csr_data;
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_alloc_release(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected rsp beat: status %0d addr %0d",
                           rsp_data.status, rsp_data.granted_address);
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.status !== rsp_data.status ||
                   want.granted_address !== rsp_data.granted_address) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("rsp mismatch: exp status %0d addr %0d, got %0d %0d",
                              want.status, want.granted_address,
                              rsp_data.status, rsp_data.granted_address);
               end
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

>>> dv/tb_variable_partition_allocator_core.sv
// Testbench top: drives allocate/release traffic and fit-policy writes.
`timescale 1ns / 1ps
module tb_variable_partition_allocator_core;
   import vpa_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid, req_ready, rsp_valid, rsp_ready;
   logic    csr_valid, csr_ready, csr_data;
   req_type req_data;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   int      send_idle_pct, recv_idle_pct;
   logic [AddrWidth-1:0] held_base[$];
   logic [AddrWidth-1:0] held_len[$];
   int      last_alloc[$];

   variable_partition_allocator_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data
   );

   vpa_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_valid, .csr_ready, .csr_data,
      .fail_count, .pending_count
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // track granted segments so releases mostly give back real allocations
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready && req_data.operation == OP_ALLOC &&
          req_data.segment_size != 0)
         ; // grant address is only known at the rsp beat
      if (!reset && rsp_valid && rsp_ready && rsp_data.status == ST_OK &&
          last_alloc.size() > 0) begin
         if (last_alloc[0] != 0) begin
            held_base.push_back(rsp_data.granted_address);
            held_len.push_back(AddrWidth'(last_alloc[0]));
         end
      end
      if (!reset && rsp_valid && rsp_ready && last_alloc.size() > 0)
         void'(last_alloc.pop_front());
      if (!reset && req_valid && req_ready)
         last_alloc.push_back(req_data.operation == OP_ALLOC ?
                              int'(req_data.segment_size) : 0);
   end

   task automatic send_beat(logic op, int size, int addr);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_data.operation = op;
      req_data.segment_size = size[AddrWidth-1:0];
      req_data.segment_address = addr[AddrWidth-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_policy(logic v);
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_valid = 1'b1;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_traffic(int n);
      int k, sz;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(1, 1500);
            send_beat(OP_ALLOC, sz, $urandom);
         end else if (k < 85 && held_base.size() > 0) begin
            k = $urandom_range(held_base.size() - 1);
            // release whole block or a piece of it
            if ($urandom_range(3) == 0 && held_len[k] > 1) begin
               sz = $urandom_range(1, int'(held_len[k]) - 1);
               send_beat(OP_RELEASE, sz, int'(held_base[k]));
               held_base[k] = AddrWidth'(int'(held_base[k]) + sz);
               held_len[k] = AddrWidth'(int'(held_len[k]) - sz);
            end else begin
               send_beat(OP_RELEASE, int'(held_len[k]), int'(held_base[k]));
               held_base.delete(k);
               held_len.delete(k);
            end
         end else begin
            send_beat(1'($urandom_range(1)), $urandom_range(32767), $urandom_range(32767));
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_data = 0;
      rsp_ready = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: zero sizes, huge, past pool end, overlap, exact fits
      send_beat(OP_ALLOC, 0, 0);
      send_beat(OP_RELEASE, 0, 5);
      send_beat(OP_RELEASE, 10, 32760);
      send_beat(OP_RELEASE, 4, 100);
      send_beat(OP_ALLOC, 32767, 32767);
      send_beat(OP_ALLOC, 1, 0);
      send_beat(OP_RELEASE, 32767, 0);
      send_beat(OP_ALLOC, 32767, 0);
      send_beat(OP_ALLOC, 1, 0);
      send_beat(OP_RELEASE, 1, 32766);
      send_beat(OP_RELEASE, 1, 0);
      send_beat(OP_RELEASE, 100, 1000);
      send_beat(OP_RELEASE, 100, 900);
      send_beat(OP_RELEASE, 100, 1100);
      send_beat(OP_RELEASE, 50, 5000);
      send_beat(OP_RELEASE, 50, 1200);
      // table full: many isolated releases
      for (int i = 0; i < 34; i++) send_beat(OP_RELEASE, 2, 8000 + 4 * i);
      write_policy(1'b1);
      send_beat(OP_ALLOC, 2, 0);
      send_beat(OP_ALLOC, 40, 0);
      send_beat(OP_ALLOC, 32767, 0);
      write_policy(1'b0);
      send_beat(OP_ALLOC, 2, 0);
      send_beat(OP_ALLOC, 30000, 0);
      send_idle_pct = 15; recv_idle_pct = 62;
      random_traffic(400);
      write_policy(1'b1);
      send_idle_pct = 62; recv_idle_pct = 15;
      random_traffic(400);
      write_policy(1'b0);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_traffic(200);
      write_policy(1'b1);
      random_traffic(200);
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
rtl/vpa_pkg.sv
rtl/vpa_seg_ram.sv
rtl/variable_partition_allocator_core.sv
dv/vpa_checker.sv
dv/tb_variable_partition_allocator_core.sv
